// ----- sv/oslm_pkg.sv -----
// ----------------------------------------------------------------------------
// oslm_pkg: shared types and constants of the output saturator / level meter
// Payload structs, register indexes, fixed-point constants, the microprogram
// table and the rounding, saturation and drive gain helpers.
// ----------------------------------------------------------------------------
package oslm_pkg;

	// field widths
	localparam int MixW       = 24;
	localparam int SampleW    = 23;
	localparam int SampleMagW = 22;
	localparam int MeterW     = 24;
	localparam int GainW      = 17;
	localparam int DriveGainW = 20;
	localparam int CoefW      = 25;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 25;

	// datapath widths
	localparam int MulAW    = 29;
	localparam int MulBW    = 31;
	localparam int ProdW    = 60;
	localparam int MixAccW  = 26;
	localparam int ArgW     = 29;
	localparam int FracBits = 25;

	// register indexes
	localparam logic [CfgIdxW-1:0] CfgVolume  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDrive   = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgAttack  = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgRelease = 2'd3;

	// constants
	localparam logic [GainW-1:0]      GainOne   = 17'd65536;
	localparam logic [CoefW-1:0]      CoefOne   = 25'd16777216;
	localparam logic [MulBW-1:0]      Headroom  = 31'd26214;
	localparam logic [SampleW-1:0]    SampleMax = 23'd4194303;
	localparam logic [MeterW-1:0]     MeterMax  = 24'hFFFFFF;
	localparam logic [GainW-1:0]      VolReset  = 17'd52429;
	localparam logic [GainW-1:0]      DrvReset  = 17'd3277;
	localparam logic [DriveGainW-1:0] GainReset = 20'd88475;
	localparam logic [CoefW-1:0]      AttReset  = 25'd47497;
	localparam logic [CoefW-1:0]      RelReset  = 25'd1522;

	// payloads
	typedef struct packed {
		logic signed [MixW-1:0] mix_in;
	} mix_req_t;

	typedef struct packed {
		logic signed [SampleW-1:0] sample_out;
		logic [MeterW-1:0]         meter_level;
	} result_t;

	// microcode fields
	localparam int StepW = 5;
	localparam int SelW  = 3;

	localparam logic [SelW-1:0] ASelVol    = 3'd0;
	localparam logic [SelW-1:0] ASelX      = 3'd1;
	localparam logic [SelW-1:0] ASelMix    = 3'd2;
	localparam logic [SelW-1:0] ASelAbsArg = 3'd3;
	localparam logic [SelW-1:0] ASelTDiff  = 3'd4;
	localparam logic [SelW-1:0] ASelXfDiff = 3'd5;
	localparam logic [SelW-1:0] ASelLDiff  = 3'd6;

	localparam logic [SelW-1:0] BSelHead  = 3'd0;
	localparam logic [SelW-1:0] BSelProd  = 3'd1;
	localparam logic [SelW-1:0] BSelGain  = 3'd2;
	localparam logic [SelW-1:0] BSelDepth = 3'd3;
	localparam logic [SelW-1:0] BSelFrac  = 3'd4;
	localparam logic [SelW-1:0] BSelDrv   = 3'd5;
	localparam logic [SelW-1:0] BSelCoef  = 3'd6;

	localparam logic [SelW-1:0] WbNone  = 3'd0;
	localparam logic [SelW-1:0] WbMix   = 3'd1;
	localparam logic [SelW-1:0] WbArg   = 3'd2;
	localparam logic [SelW-1:0] WbAddr  = 3'd3;
	localparam logic [SelW-1:0] WbTanh  = 3'd4;
	localparam logic [SelW-1:0] WbXf    = 3'd5;
	localparam logic [SelW-1:0] WbTgt   = 3'd6;
	localparam logic [SelW-1:0] WbLevel = 3'd7;

	// entry of the final tanh clip
	localparam logic [StepW-1:0] StepFinalClip = 5'd11;

	typedef struct packed {
		logic [SelW-1:0]  a_sel;
		logic [SelW-1:0]  b_sel;
		logic             mul_en;
		logic [SelW-1:0]  wb;
		logic             jmp_nodrive;
		logic [StepW-1:0] target;
		logic             last;
	} ucode_t;

	// microprogram: one control word per step
	function automatic ucode_t uc_rom(input logic [StepW-1:0] step);
		ucode_t w;
		w = '0;
		case (step)
			5'd0: begin
				w.a_sel = ASelVol; w.b_sel = BSelHead; w.mul_en = 1'b1;
			end
			5'd1: begin
				w.a_sel = ASelX; w.b_sel = BSelProd; w.mul_en = 1'b1;
			end
			5'd2: begin
				w.wb = WbMix; w.jmp_nodrive = 1'b1; w.target = StepFinalClip;
			end
			5'd3: begin
				w.a_sel = ASelMix; w.b_sel = BSelGain; w.mul_en = 1'b1;
			end
			5'd4: begin
				w.wb = WbArg;
			end
			5'd5: begin
				w.a_sel = ASelAbsArg; w.b_sel = BSelDepth; w.mul_en = 1'b1;
			end
			5'd6: begin
				w.wb = WbAddr;
			end
			5'd7: begin
				w.a_sel = ASelTDiff; w.b_sel = BSelFrac; w.mul_en = 1'b1;
			end
			5'd8: begin
				w.wb = WbTanh;
			end
			5'd9: begin
				w.a_sel = ASelXfDiff; w.b_sel = BSelDrv; w.mul_en = 1'b1;
			end
			5'd10: begin
				w.wb = WbXf;
			end
			5'd11: begin
				w.a_sel = ASelAbsArg; w.b_sel = BSelDepth; w.mul_en = 1'b1;
			end
			5'd12: begin
				w.wb = WbAddr;
			end
			5'd13: begin
				w.a_sel = ASelTDiff; w.b_sel = BSelFrac; w.mul_en = 1'b1;
			end
			5'd14: begin
				w.wb = WbTanh;
			end
			5'd15: begin
				w.wb = WbTgt;
			end
			5'd16: begin
				w.a_sel = ASelLDiff; w.b_sel = BSelCoef; w.mul_en = 1'b1;
			end
			5'd17: begin
				w.wb = WbLevel; w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	// arithmetic shift right by n, rounding half away from zero
	function automatic logic signed [ProdW-1:0] round_shr(
		input logic signed [ProdW-1:0] v,
		input int unsigned n
	);
		logic [ProdW-1:0] half;
		logic signed [ProdW-1:0] bias;
		half = ProdW'(1) << (n - 1);
		bias = $signed(half - {{(ProdW-1){1'b0}}, v[ProdW-1]});
		return (v + bias) >>> n;
	endfunction

	function automatic logic [GainW-1:0] sat_gain(input logic [GainW-1:0] v);
		return (v > GainOne) ? GainOne : v;
	endfunction

	function automatic logic [CoefW-1:0] sat_coef(input logic [CoefW-1:0] v);
		return (v > CoefOne) ? CoefOne : v;
	endfunction

	// 1 + 7 * drive, Q4.16
	function automatic logic [DriveGainW-1:0] drive_gain(input logic [GainW-1:0] d);
		return DriveGainW'(GainOne) + {d, 3'b000} - DriveGainW'(d);
	endfunction

endpackage

// ----- sv/oslm_stream_if.sv -----
// ----------------------------------------------------------------------------
// oslm_stream_if: valid/ready channel
// Carries one payload per request; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface oslm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/oslm_tanh_rom.sv -----
// ----------------------------------------------------------------------------
// oslm_tanh_rom: tanh table with two registered read ports
// Entry i holds tanh(8 * i / depth) in Q.22, built at elaboration with the
// same integer series as the fixed-point spec. Reads entries addr and addr+1.
// ----------------------------------------------------------------------------
module oslm_tanh_rom #(
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     rd_en,
	input  logic [$clog2(TANH_TABLE_DEPTH+1)-1:0]    addr,
	output logic [oslm_pkg::SampleMagW-1:0]          t0,
	output logic [oslm_pkg::SampleMagW-1:0]          t1
);

	localparam int AddrW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam logic [63:0] ExpM1Q32 = 64'd1580030169;
	localparam logic [63:0] OneQ32   = 64'h1_0000_0000;

	typedef logic [oslm_pkg::SampleMagW-1:0] tanh_rom_t [0:TANH_TABLE_DEPTH];

	// unsigned quotient by shift and subtract, elaboration only
	function automatic logic [63:0] udiv64(
		input logic [63:0] num,
		input logic [63:0] den
	);
		logic [63:0] q;
		logic [64:0] r;
		int          i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-num / depth) in Q0.32
	function automatic logic [63:0] exp_neg_q32(input int unsigned num);
		logic [63:0] k;
		logic [63:0] rem;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] e;
		longint      sum;
		int unsigned n;
		k    = udiv64(64'(num), 64'(TANH_TABLE_DEPTH));
		rem  = 64'(num) - k * 64'(TANH_TABLE_DEPTH);
		f    = udiv64(rem << 32, 64'(TANH_TABLE_DEPTH));
		sum  = longint'(OneQ32);
		term = OneQ32;
		for (n = 1; n <= 20; n++) begin
			term = udiv64((term * f) >> 32, 64'(n));
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		e = 64'(sum);
		for (n = 0; 64'(n) < k; n++)
			e = (e * ExpM1Q32 + 64'h8000_0000) >> 32;
		return e;
	endfunction

	function automatic tanh_rom_t build_rom();
		tanh_rom_t   rom;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] v;
		int unsigned i;
		for (i = 0; i <= TANH_TABLE_DEPTH; i++) begin
			e   = exp_neg_q32(16 * i);
			den = OneQ32 + e;
			v   = udiv64(((OneQ32 - e) << 22) + (den >> 1), den);
			if (v > 64'(oslm_pkg::SampleMax))
				v = 64'(oslm_pkg::SampleMax);
			rom[i] = v[oslm_pkg::SampleMagW-1:0];
		end
		return rom;
	endfunction

	localparam tanh_rom_t TanhRom = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			t0 <= TanhRom[addr];
			t1 <= TanhRom[AddrW'(addr + 1'b1)];
		end
	end

endmodule

// ----- sv/output_saturator_level_meter.sv -----
// ----------------------------------------------------------------------------
// output_saturator_level_meter: tanh soft clipper with peak level meter
// Microcoded datapath around one shared multiplier and a tanh table.
// ----------------------------------------------------------------------------
// One request on mix carries a Q4.19 voice sum. It is scaled by volume and a
// 0.4 headroom, crossfaded by drive toward tanh of the driven sample, clipped
// once more by tanh and returned on result with the updated Q0.24 meter level.
// One request is worked at a time: the next request is taken only after the
// last step of the microprogram, and with zero drive the program jumps from
// the mix writeback to the final tanh clip. The pace is set by the single
// 29x31 multiplier, which a microprogram steps through every product with a
// writeback step after each one but the first. A finished result sits in the
// output register while the next request is already being worked; the
// program stalls on its last step only if that register is still full. The
// tanh table (TANH_TABLE_DEPTH + 1 entries) is a ROM built at elaboration, so
// there is no clearing pass after reset. The user must write registers only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module output_saturator_level_meter #(
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	oslm_stream_if.sink                       mix,
	oslm_stream_if.source                     result,
	input  logic                              cfg_we,
	input  logic [oslm_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [oslm_pkg::CfgDataW-1:0]     cfg_data
);

	localparam int RomAW = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int IdxW  = oslm_pkg::ProdW - oslm_pkg::FracBits;

	// configuration, stored already saturated
	logic [oslm_pkg::GainW-1:0]      vol_q;
	logic [oslm_pkg::GainW-1:0]      drv_q;
	logic [oslm_pkg::DriveGainW-1:0] gain_q;
	logic [oslm_pkg::CoefW-1:0]      att_q;
	logic [oslm_pkg::CoefW-1:0]      rel_q;

	// sequencer
	logic                        busy_q;
	logic [oslm_pkg::StepW-1:0]  step_q;
	oslm_pkg::ucode_t            uc;
	logic                        accept;
	logic                        stall;
	logic                        advance;

	// datapath registers
	logic signed [oslm_pkg::MixW-1:0]    x_q;
	logic signed [oslm_pkg::ProdW-1:0]   prod_q;
	logic signed [oslm_pkg::MixAccW-1:0] mix_q;
	logic signed [oslm_pkg::ArgW-1:0]    arg_q;
	logic [oslm_pkg::FracBits-1:0]       frac_q;
	logic                                ovf_q;
	logic signed [oslm_pkg::SampleW-1:0] tanh_q;
	logic [oslm_pkg::MeterW-1:0]         tgt_q;
	logic [oslm_pkg::MeterW-1:0]         level_q;
	logic                                out_valid_q;
	oslm_pkg::result_t                   out_q;

	// ROM
	logic [RomAW-1:0]                  rom_addr;
	logic [oslm_pkg::SampleMagW-1:0]   t0;
	logic [oslm_pkg::SampleMagW-1:0]   t1;

	// operand and result logic
	logic signed [oslm_pkg::MulAW-1:0]          mul_a;
	logic [oslm_pkg::MulBW-1:0]                 mul_b;
	logic signed [oslm_pkg::MulAW+oslm_pkg::MulBW:0] prod_full;
	logic [oslm_pkg::ArgW-1:0]                  abs_arg;
	logic signed [oslm_pkg::SampleW-1:0]        tdiff;
	logic signed [oslm_pkg::MixAccW:0]          xfdiff;
	logic signed [oslm_pkg::MeterW:0]           ldiff;
	logic [IdxW-1:0]                            idx;
	logic                                       idx_ovf;
	logic signed [oslm_pkg::ProdW-1:0]          rnd29;
	logic signed [oslm_pkg::ProdW-1:0]          rnd16;
	logic signed [oslm_pkg::ProdW-1:0]          rnd25;
	logic signed [oslm_pkg::ProdW-1:0]          rnd24;
	logic [oslm_pkg::SampleW-1:0]               tmag;
	logic signed [oslm_pkg::MixAccW-1:0]        mix_xf;
	logic [oslm_pkg::SampleW-1:0]               ymag;
	logic [oslm_pkg::SampleW+4:0]               y48;
	logic signed [oslm_pkg::MeterW+2:0]         nl;
	logic [oslm_pkg::MeterW-1:0]                level_new;

	// ---------------------------------------------------------------- control
	assign uc      = oslm_pkg::uc_rom(step_q);
	assign accept  = mix.valid && mix.ready;
	// last step writes the output register; hold it while that is still full
	assign stall   = (uc.wb == oslm_pkg::WbLevel) && out_valid_q && !result.ready;
	assign advance = busy_q && !stall;

	assign mix.ready      = !busy_q;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (advance) begin
			if (uc.last)
				busy_q <= 1'b0;
			if (uc.jmp_nodrive && (drv_q == '0))
				step_q <= uc.target;
			else
				step_q <= step_q + 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= oslm_pkg::VolReset;
			drv_q  <= oslm_pkg::DrvReset;
			gain_q <= oslm_pkg::GainReset;
			att_q  <= oslm_pkg::AttReset;
			rel_q  <= oslm_pkg::RelReset;
		end else if (cfg_we) begin
			case (cfg_index)
				oslm_pkg::CfgVolume: begin
					vol_q <= oslm_pkg::sat_gain(cfg_data[oslm_pkg::GainW-1:0]);
				end
				oslm_pkg::CfgDrive: begin
					drv_q  <= oslm_pkg::sat_gain(cfg_data[oslm_pkg::GainW-1:0]);
					gain_q <= oslm_pkg::drive_gain(
						oslm_pkg::sat_gain(cfg_data[oslm_pkg::GainW-1:0]));
				end
				oslm_pkg::CfgAttack: begin
					att_q <= oslm_pkg::sat_coef(cfg_data);
				end
				oslm_pkg::CfgRelease: begin
					rel_q <= oslm_pkg::sat_coef(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// -------------------------------------------------------------- operands
	assign abs_arg = arg_q[oslm_pkg::ArgW-1] ? (-arg_q) : arg_q;
	assign tdiff   = $signed({1'b0, t1}) - $signed({1'b0, t0});
	assign xfdiff  = {{(oslm_pkg::MixAccW+1-oslm_pkg::SampleW){tanh_q[oslm_pkg::SampleW-1]}},
		tanh_q} - {mix_q[oslm_pkg::MixAccW-1], mix_q};
	assign ldiff   = $signed({1'b0, tgt_q}) - $signed({1'b0, level_q});

	always_comb begin
		case (uc.a_sel)
			oslm_pkg::ASelVol:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::GainW){1'b0}}, vol_q};
			oslm_pkg::ASelX:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::MixW){x_q[oslm_pkg::MixW-1]}}, x_q};
			oslm_pkg::ASelMix:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::MixAccW){mix_q[oslm_pkg::MixAccW-1]}},
					mix_q};
			oslm_pkg::ASelAbsArg:
				mul_a = $signed(abs_arg);
			oslm_pkg::ASelTDiff:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::SampleW){tdiff[oslm_pkg::SampleW-1]}},
					tdiff};
			oslm_pkg::ASelXfDiff:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::MixAccW-1){xfdiff[oslm_pkg::MixAccW]}},
					xfdiff};
			oslm_pkg::ASelLDiff:
				mul_a = {{(oslm_pkg::MulAW-oslm_pkg::MeterW-1){ldiff[oslm_pkg::MeterW]}},
					ldiff};
			default:
				mul_a = '0;
		endcase
	end

	always_comb begin
		case (uc.b_sel)
			oslm_pkg::BSelHead:
				mul_b = oslm_pkg::Headroom;
			oslm_pkg::BSelProd:
				mul_b = prod_q[oslm_pkg::MulBW-1:0];
			oslm_pkg::BSelGain:
				mul_b = {{(oslm_pkg::MulBW-oslm_pkg::DriveGainW){1'b0}}, gain_q};
			oslm_pkg::BSelDepth:
				mul_b = oslm_pkg::MulBW'(TANH_TABLE_DEPTH);
			oslm_pkg::BSelFrac:
				mul_b = {{(oslm_pkg::MulBW-oslm_pkg::FracBits){1'b0}}, frac_q};
			oslm_pkg::BSelDrv:
				mul_b = {{(oslm_pkg::MulBW-oslm_pkg::GainW){1'b0}}, drv_q};
			oslm_pkg::BSelCoef:
				// attack while the target is above the level, release otherwise
				mul_b = {{(oslm_pkg::MulBW-oslm_pkg::CoefW){1'b0}},
					(tgt_q > level_q) ? att_q : rel_q};
			default:
				mul_b = '0;
		endcase
	end

	assign prod_full = mul_a * $signed({1'b0, mul_b});

	// ------------------------------------------------------------ writebacks
	assign rnd29 = oslm_pkg::round_shr(prod_q, 29);
	assign rnd16 = oslm_pkg::round_shr(prod_q, 16);
	assign rnd25 = oslm_pkg::round_shr(prod_q, oslm_pkg::FracBits);
	assign rnd24 = oslm_pkg::round_shr(prod_q, 24);

	// table position = |arg| * depth; integer part from bit 25 up
	assign idx      = prod_q[oslm_pkg::ProdW-1:oslm_pkg::FracBits];
	assign idx_ovf  = idx >= IdxW'(TANH_TABLE_DEPTH);
	assign rom_addr = idx_ovf ? '0 : idx[RomAW-1:0];

	// interpolated magnitude, pinned to full scale past the table's end
	assign tmag   = ovf_q ? oslm_pkg::SampleMax
		: ({1'b0, t0} + rnd25[oslm_pkg::SampleW-1:0]);
	assign mix_xf = mix_q + rnd16[oslm_pkg::MixAccW-1:0];

	// meter target = min(|y| * 48, max)
	assign ymag = tanh_q[oslm_pkg::SampleW-1] ? (-tanh_q) : tanh_q;
	assign y48  = {ymag, 5'b00000} + {1'b0, ymag, 4'b0000};

	assign nl = $signed({3'b000, level_q}) + rnd24[oslm_pkg::MeterW+2:0];
	always_comb begin
		if (nl < 0)
			level_new = '0;
		else if (nl > $signed({3'b000, oslm_pkg::MeterMax}))
			level_new = oslm_pkg::MeterMax;
		else
			level_new = nl[oslm_pkg::MeterW-1:0];
	end

	oslm_tanh_rom #(
		.TANH_TABLE_DEPTH(TANH_TABLE_DEPTH)
	) u_tanh_rom (
		.clk   (clk),
		.rd_en (advance && (uc.wb == oslm_pkg::WbAddr)),
		.addr  (rom_addr),
		.t0    (t0),
		.t1    (t1)
	);

	always_ff @(posedge clk) begin
		if (accept)
			x_q <= mix.payload.mix_in;
		if (advance) begin
			if (uc.mul_en)
				prod_q <= prod_full[oslm_pkg::ProdW-1:0];
			case (uc.wb)
				oslm_pkg::WbMix: begin
					mix_q <= rnd29[oslm_pkg::MixAccW-1:0];
					arg_q <= rnd29[oslm_pkg::ArgW-1:0];
				end
				oslm_pkg::WbArg: begin
					arg_q <= rnd16[oslm_pkg::ArgW-1:0];
				end
				oslm_pkg::WbAddr: begin
					ovf_q  <= idx_ovf;
					frac_q <= prod_q[oslm_pkg::FracBits-1:0];
				end
				oslm_pkg::WbTanh: begin
					tanh_q <= arg_q[oslm_pkg::ArgW-1] ? (-tmag) : tmag;
				end
				oslm_pkg::WbXf: begin
					mix_q <= mix_xf;
					arg_q <= {{(oslm_pkg::ArgW-oslm_pkg::MixAccW){mix_xf[oslm_pkg::MixAccW-1]}},
						mix_xf};
				end
				oslm_pkg::WbTgt: begin
					tgt_q <= (y48 > {4'b0000, oslm_pkg::MeterMax}) ? oslm_pkg::MeterMax
						: y48[oslm_pkg::MeterW-1:0];
				end
				oslm_pkg::WbLevel: begin
					out_q.sample_out  <= tanh_q;
					out_q.meter_level <= level_new;
				end
				default: begin
				end
			endcase
		end
	end

	// meter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && (uc.wb == oslm_pkg::WbLevel)) begin
				level_q     <= level_new;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/oslm_checker.sv -----
// ----------------------------------------------------------------------------
// oslm_port_checker: port-level assertions for the output saturator
// Watches the request and result channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module oslm_port_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [oslm_pkg::SampleW-1:0] sample_out,
	input logic [oslm_pkg::MeterW-1:0]         meter_level
);

	localparam logic [oslm_pkg::SampleW-1:0] SampleMin = 23'h400000;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
			&& $stable(meter_level))
		else $error("result changed while stalled");

	// one request in flight: ready drops right after acceptance
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// no result rises in the cycle after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// tanh output is symmetric, never the most negative code
	a_sample_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_out != SampleMin)
		else $error("sample out of symmetric range");

endmodule

bind output_saturator_level_meter oslm_port_checker u_oslm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (mix.valid),
	.in_ready    (mix.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.sample_out  (result.payload.sample_out),
	.meter_level (result.payload.meter_level)
);
